// ===== rtl/core/dilated_max_pool_2d_macros.svh =====
// Assertion macros shared by the dilated max pooling modules.
`ifndef DILATED_MAX_POOL_2D_MACROS_SVH
`define DILATED_MAX_POOL_2D_MACROS_SVH

// Same-cycle implication, sampled on clock, quiet during reset
`define DMP_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, quiet during reset
`define DMP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/dmp_pkg.sv =====
// Types, constants and register codes of the dilated max pooling block.
package dmp_pkg;

   // Image plane geometry and storage
   localparam int IMAGE_WIDTH  = 32;
   localparam int IMAGE_HEIGHT = 32;
   localparam int MEM_DEPTH    = 1024;
   localparam int MEM_AW       = 10;
   localparam int VALUE_W      = 16;
   localparam int ROW_W        = 5;
   localparam int COL_W        = 5;
   localparam int COORD_W      = 12;
   localparam int SIZE_W       = 4;
   localparam int PAD_W        = 3;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 4;

   localparam logic [MEM_AW-1:0]         IMAGE_WIDTH_A  = MEM_AW'(IMAGE_WIDTH);
   localparam logic signed [COORD_W-1:0] IMAGE_WIDTH_C  = COORD_W'(IMAGE_WIDTH);
   localparam logic signed [COORD_W-1:0] IMAGE_HEIGHT_C = COORD_W'(IMAGE_HEIGHT);
   localparam logic signed [COORD_W-1:0] COORD_ONE      = COORD_W'(1);
   localparam logic signed [VALUE_W-1:0] VALUE_MIN      = {1'b1, {(VALUE_W-1){1'b0}}};

   // Request command codes
   localparam logic CMD_WRITE_PIXEL = 1'b0;
   localparam logic CMD_POOL        = 1'b1;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_KERNEL_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_KERNEL_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_STRIDE_X      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_STRIDE_Y      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PAD_X         = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_PAD_Y         = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_DILATION_X    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_DILATION_Y    = 3'd7;

   // Register reset values
   localparam logic [SIZE_W-1:0] KERNEL_RESET   = 4'd2;
   localparam logic [SIZE_W-1:0] STRIDE_RESET   = 4'd2;
   localparam logic [PAD_W-1:0]  PAD_RESET      = 3'd0;
   localparam logic [SIZE_W-1:0] DILATION_RESET = 4'd1;

   typedef struct packed {
      logic [SIZE_W-1:0] kernel_width;
      logic [SIZE_W-1:0] kernel_height;
      logic [SIZE_W-1:0] stride_x;
      logic [SIZE_W-1:0] stride_y;
      logic [PAD_W-1:0]  pad_x;
      logic [PAD_W-1:0]  pad_y;
      logic [SIZE_W-1:0] dilation_x;
      logic [SIZE_W-1:0] dilation_y;
   } cfg_type;

   // Controller to datapath commands
   typedef struct packed {
      logic mem_write;
      logic load_query;
      logic setup;
      logic adjust;
      logic scan_init;
      logic scan_step;
      logic load_result;
   } ctrl_type;

   // Datapath to controller status
   typedef struct packed {
      logic adjust_done;
      logic rows_done;
   } status_type;

endpackage

// ===== rtl/core/dmp_req_if.sv =====
// Request channel: pixel writes and pooling queries.
interface dmp_req_if
   import dmp_pkg::*;
   ();
   logic                      valid;
   logic                      ready;
   logic                      command;
   logic [MEM_AW-1:0]         pixel_addr;
   logic signed [VALUE_W-1:0] pixel_value;
   logic [ROW_W-1:0]          out_row;
   logic [COL_W-1:0]          out_col;

   modport source (output valid, command, pixel_addr, pixel_value, out_row, out_col,
                   input ready);
   modport sink (input valid, command, pixel_addr, pixel_value, out_row, out_col,
                 output ready);
endinterface

// ===== rtl/core/dmp_rsp_if.sv =====
// Response channel: pooling results.
interface dmp_rsp_if
   import dmp_pkg::*;
   ();
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] max_value;
   logic [MEM_AW-1:0]         max_index;
   logic                      window_empty;

   modport source (output valid, max_value, max_index, window_empty, input ready);
   modport sink (input valid, max_value, max_index, window_empty, output ready);
endinterface

// ===== rtl/core/dilated_max_pool_2d.sv =====
// Top level of the dilated 2-D max pooling block.
//
//   channel   direction  handshake        payload
//   req_bus   in         valid / ready    command, pixel_addr, pixel_value, out_row, out_col
//   rsp_bus   out        valid / ready    max_value, max_index, window_empty
//   csr_*     in         csr_we           csr_index, csr_wdata
//
// A pixel write goes to the plane memory on acceptance. A query loads its position, sets up
// the window, takes 0 to 7 steps that bring a negative window start to zero or above, scans
// taps row by row and loads the result; one plane memory read port gives one tap per cycle.
// Reset is synchronous: it clears the sequencer, the response valid and the registers to
// 2x2 kernel, 2x2 stride, no padding, unit dilation. The plane memory is not cleared.
// A result waiting on rsp_bus does not block the next request; only its write-back does.
module dilated_max_pool_2d
   import dmp_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   dmp_req_if.sink                 req_bus,
   dmp_rsp_if.source               rsp_bus,
   input  logic                    csr_we,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   cfg_type    cfg_ff, cfg_in;
   ctrl_type   ctrl;
   status_type status;

   // Configuration register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_KERNEL_WIDTH:  cfg_in.kernel_width  = csr_wdata;
            REG_KERNEL_HEIGHT: cfg_in.kernel_height = csr_wdata;
            REG_STRIDE_X:      cfg_in.stride_x      = csr_wdata;
            REG_STRIDE_Y:      cfg_in.stride_y      = csr_wdata;
            REG_PAD_X:         cfg_in.pad_x         = csr_wdata[PAD_W-1:0];
            REG_PAD_Y:         cfg_in.pad_y         = csr_wdata[PAD_W-1:0];
            REG_DILATION_X:    cfg_in.dilation_x    = csr_wdata;
            REG_DILATION_Y:    cfg_in.dilation_y    = csr_wdata;
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.kernel_width  <= KERNEL_RESET;
         cfg_ff.kernel_height <= KERNEL_RESET;
         cfg_ff.stride_x      <= STRIDE_RESET;
         cfg_ff.stride_y      <= STRIDE_RESET;
         cfg_ff.pad_x         <= PAD_RESET;
         cfg_ff.pad_y         <= PAD_RESET;
         cfg_ff.dilation_x    <= DILATION_RESET;
         cfg_ff.dilation_y    <= DILATION_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dmp_controller u_controller (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_bus.valid),
      .req_command (req_bus.command),
      .req_ready   (req_bus.ready),
      .rsp_ready   (rsp_bus.ready),
      .rsp_valid   (rsp_bus.valid),
      .status      (status),
      .ctrl        (ctrl)
   );

   dmp_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .ctrl         (ctrl),
      .status       (status),
      .pixel_addr   (req_bus.pixel_addr),
      .pixel_value  (req_bus.pixel_value),
      .out_row      (req_bus.out_row),
      .out_col      (req_bus.out_col),
      .max_value    (rsp_bus.max_value),
      .max_index    (rsp_bus.max_index),
      .window_empty (rsp_bus.window_empty)
   );

endmodule

// ===== rtl/core/dmp_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module dmp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/dmp_controller.sv =====
// Sequencer for pixel writes and the window scan of a pooling query.
`include "dilated_max_pool_2d_macros.svh"
module dmp_controller
   import dmp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_command,
   output logic       req_ready,
   input  logic       rsp_ready,
   output logic       rsp_valid,
   input  status_type status,
   output ctrl_type   ctrl
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SETUP  = 5'b00010,
      ST_ADJUST = 5'b00100,
      ST_SCAN   = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      req_accept;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign rsp_valid  = rsp_valid_ff;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      ctrl     = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_command == CMD_POOL) begin
                  ctrl.load_query = 1'b1;
                  state_in        = ST_SETUP;
               end else begin
                  ctrl.mem_write = 1'b1;
               end
            end
         end
         ST_SETUP: begin
            ctrl.setup = 1'b1;
            state_in   = ST_ADJUST;
         end
         ST_ADJUST: begin
            if (status.adjust_done) begin
               ctrl.scan_init = 1'b1;
               state_in       = ST_SCAN;
            end else begin
               ctrl.adjust = 1'b1;
            end
         end
         ST_SCAN: begin
            if (status.rows_done) begin
               state_in = ST_FINISH;
            end else begin
               ctrl.scan_step = 1'b1;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               ctrl.load_result = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold a finished result until it is taken
   always_comb begin
      if (ctrl.load_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `DMP_ASSERT_IMPL(a_no_overwrite, ctrl.load_result, (!rsp_valid_ff || rsp_ready), "pending result overwritten")
   `DMP_ASSERT_NEXT(a_query_setup, (req_accept && req_command == CMD_POOL), (state_ff == ST_SETUP), "query did not start setup")
   `DMP_ASSERT_NEXT(a_result_shown, ctrl.load_result, (rsp_valid_ff && state_ff == ST_IDLE), "result not presented")

endmodule

// ===== rtl/core/dmp_datapath.sv =====
// Window bounds, tap address walk, plane memory and running maximum.
`include "dilated_max_pool_2d_macros.svh"
module dmp_datapath
   import dmp_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  cfg_type                   cfg,
   input  ctrl_type                  ctrl,
   output status_type                status,
   input  logic [MEM_AW-1:0]         pixel_addr,
   input  logic signed [VALUE_W-1:0] pixel_value,
   input  logic [ROW_W-1:0]          out_row,
   input  logic [COL_W-1:0]          out_col,
   output logic signed [VALUE_W-1:0] max_value,
   output logic [MEM_AW-1:0]         max_index,
   output logic                      window_empty
);

   logic [ROW_W-1:0]          row_ff;
   logic [COL_W-1:0]          col_ff;
   logic signed [COORD_W-1:0] y0_ff, x0_ff, y1_ff, x1_ff;
   logic signed [COORD_W-1:0] cur_y_ff, cur_x_ff;
   logic signed [COORD_W-1:0] y0_in, x0_in, y1_in, x1_in, cur_y_in, cur_x_in;
   logic                      tap_valid_ff;
   logic [MEM_AW-1:0]         tap_addr_q_ff;
   logic                      found_ff, found_in;
   logic signed [VALUE_W-1:0] best_ff, best_in;
   logic [MEM_AW-1:0]         best_idx_ff, best_idx_in;
   logic signed [VALUE_W-1:0] max_value_ff;
   logic [MEM_AW-1:0]         max_index_ff;
   logic                      window_empty_ff;

   logic [SIZE_W-1:0]          dil_x, dil_y;
   logic signed [COORD_W-1:0]  dx_c, dy_c, kw_c, kh_c;
   logic [ROW_W+SIZE_W-1:0]    row_prod;
   logic [COL_W+SIZE_W-1:0]    col_prod;
   logic signed [COORD_W-1:0]  y0_calc, x0_calc, y1_raw, x1_raw;
   logic                       col_in_range, tap_issue;
   logic [MEM_AW-1:0]          tap_addr;
   logic [VALUE_W-1:0]         rd_data;
   logic signed [VALUE_W-1:0]  tap_value;

   // Zero dilation counts as one
   assign dil_x = (cfg.dilation_x == '0) ? SIZE_W'(1) : cfg.dilation_x;
   assign dil_y = (cfg.dilation_y == '0) ? SIZE_W'(1) : cfg.dilation_y;
   assign dx_c  = $signed(COORD_W'(dil_x));
   assign dy_c  = $signed(COORD_W'(dil_y));
   assign kw_c  = $signed(COORD_W'(cfg.kernel_width));
   assign kh_c  = $signed(COORD_W'(cfg.kernel_height));

   // Window start and clipped end
   assign row_prod = (ROW_W+SIZE_W)'(row_ff) * (ROW_W+SIZE_W)'(cfg.stride_y);
   assign col_prod = (COL_W+SIZE_W)'(col_ff) * (COL_W+SIZE_W)'(cfg.stride_x);
   assign y0_calc  = $signed(COORD_W'(row_prod)) - $signed(COORD_W'(cfg.pad_y));
   assign x0_calc  = $signed(COORD_W'(col_prod)) - $signed(COORD_W'(cfg.pad_x));
   assign y1_raw   = y0_calc + (kh_c - COORD_ONE) * dy_c + COORD_ONE;
   assign x1_raw   = x0_calc + (kw_c - COORD_ONE) * dx_c + COORD_ONE;

   // Tap address, wrapped to the memory depth
   assign tap_addr     = cur_y_ff[MEM_AW-1:0] * IMAGE_WIDTH_A + cur_x_ff[MEM_AW-1:0];
   assign col_in_range = (cur_x_ff < x1_ff);
   assign tap_issue    = ctrl.scan_step && !status.rows_done && col_in_range;

   assign status.adjust_done = !y0_ff[COORD_W-1] && !x0_ff[COORD_W-1];
   assign status.rows_done   = !(cur_y_ff < y1_ff);

   dmp_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (MEM_DEPTH)
   ) u_plane_ram (
      .clock (clock),
      .we    (ctrl.mem_write),
      .waddr (pixel_addr),
      .wdata (pixel_value),
      .raddr (tap_addr),
      .rdata (rd_data)
   );

   assign tap_value = $signed(rd_data);

   // Bounds: compute, step negative starts up, walk rows and columns
   always_comb begin
      y0_in    = y0_ff;
      x0_in    = x0_ff;
      y1_in    = y1_ff;
      x1_in    = x1_ff;
      cur_y_in = cur_y_ff;
      cur_x_in = cur_x_ff;
      if (ctrl.setup) begin
         y0_in = y0_calc;
         x0_in = x0_calc;
         y1_in = (y1_raw > IMAGE_HEIGHT_C) ? IMAGE_HEIGHT_C : y1_raw;
         x1_in = (x1_raw > IMAGE_WIDTH_C) ? IMAGE_WIDTH_C : x1_raw;
      end
      if (ctrl.adjust) begin
         if (y0_ff[COORD_W-1]) begin
            y0_in = y0_ff + dy_c;
         end
         if (x0_ff[COORD_W-1]) begin
            x0_in = x0_ff + dx_c;
         end
      end
      if (ctrl.scan_init) begin
         cur_y_in = y0_ff;
         cur_x_in = x0_ff;
      end
      if (ctrl.scan_step && !status.rows_done) begin
         if (col_in_range) begin
            cur_x_in = cur_x_ff + dx_c;
         end else begin
            cur_y_in = cur_y_ff + dy_c;
            cur_x_in = x0_ff;
         end
      end
   end

   // Keep the first strict maximum
   always_comb begin
      found_in    = found_ff;
      best_in     = best_ff;
      best_idx_in = best_idx_ff;
      if (ctrl.load_query) begin
         found_in    = 1'b0;
         best_in     = VALUE_MIN;
         best_idx_in = '0;
      end else if (tap_valid_ff && (!found_ff || tap_value > best_ff)) begin
         found_in    = 1'b1;
         best_in     = tap_value;
         best_idx_in = tap_addr_q_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         tap_valid_ff <= tap_issue;
         found_ff     <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_query) begin
         row_ff <= out_row;
         col_ff <= out_col;
      end
      y0_ff         <= y0_in;
      x0_ff         <= x0_in;
      y1_ff         <= y1_in;
      x1_ff         <= x1_in;
      cur_y_ff      <= cur_y_in;
      cur_x_ff      <= cur_x_in;
      tap_addr_q_ff <= tap_addr;
      best_ff       <= best_in;
      best_idx_ff   <= best_idx_in;
      if (ctrl.load_result) begin
         max_value_ff    <= best_ff;
         max_index_ff    <= best_idx_ff;
         window_empty_ff <= !found_ff;
      end
   end

   assign max_value    = max_value_ff;
   assign max_index    = max_index_ff;
   assign window_empty = window_empty_ff;

   `DMP_ASSERT_NEXT(a_tap_sets_found, tap_valid_ff, found_ff, "compared tap left no maximum")
   `DMP_ASSERT_IMPL(a_scan_start_inside, ctrl.scan_init, status.adjust_done, "scan started at negative coordinate")
   `DMP_ASSERT_IMPL(a_no_tap_in_flight, ctrl.load_result, !tap_valid_ff, "result taken with tap pending")

endmodule
